>>> hw/rtl/mpjs_pkg.sv
// Shared types, constants and key/order functions for the job scheduler.
// No dependencies; used by the cell, accumulator and top-level modules.
`timescale 1ns / 1ps

package mpjs_pkg;

    localparam int TableDepth = 16;

    localparam logic [1:0] ModeNew    = 2'd0;
    localparam logic [1:0] ModeTick   = 2'd1;
    localparam logic [1:0] ModeFinish = 2'd2;
    localparam logic [1:0] ModeNop    = 2'd3;

    localparam logic [2:0] PolFcfs  = 3'd0;
    localparam logic [2:0] PolPri   = 3'd1;
    localparam logic [2:0] PolPpri  = 3'd2;
    localparam logic [2:0] PolPsrtf = 3'd3;
    localparam logic [2:0] PolRr    = 3'd4;
    localparam logic [2:0] PolSjf   = 3'd5;

    localparam logic [47:0] MaxU48 = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] arrival;
        logic [15:0] remaining;
        logic [15:0] required;
        logic [31:0] last_run;
        logic        has_run;
        logic [31:0] start;
        logic        started;
        logic [7:0]  priority_lvl;
    } t_job;

    // Commands broadcast to every cell.
    typedef struct packed {
        logic insert;   // place r_new ahead of the first cell it goes before
        logic pop;      // every cell takes its right neighbor
        logic charge;   // head cell is charged one tick
    } t_cell_cmd;

    // Sort key, 33 bits: under RR a job that never ran gets key 0 (the -1 of the
    // ordering) and a job that ran gets bit 32 set above its last run time
    function automatic logic [32:0] key_of(input logic [2:0] pol, input t_job j);
        logic [32:0] k;
        k = '0;
        unique case (pol)
            PolPri, PolPpri: k = {25'd0, j.priority_lvl};
            PolPsrtf:        k = {17'd0, j.remaining};
            PolRr:           k = j.has_run ? {1'b1, j.last_run} : 33'd0;
            PolSjf:          k = {17'd0, j.required};
            default:         k = '0;
        endcase
        return k;
    endfunction

    function automatic logic goes_before(input logic [2:0] pol, input t_job a,
                                         input t_job b);
        logic [32:0] ka;
        logic [32:0] kb;
        ka = key_of(pol, a);
        kb = key_of(pol, b);
        if (ka != kb) return ka < kb;
        return a.arrival < b.arrival;
    endfunction

endpackage

>>> hw/rtl/multi_policy_job_scheduler.sv
// Top level of the multi-policy job scheduler: APB policy register, control
// sequencer, chain of table cells and totals. Depends on mpjs_pkg, mpjs_cell, mpjs_totals.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake           Payload
//  input    in         i_valid / o_stall   mode, job_id, time_now, run_length, ...
//  output   out        o_valid / i_stall   next_valid, next_job_id, dropped, sums
//  config   in         APB psel/penable    policy at address 0
//
// Without output stalls an item passes through accept, table update (insert,
// pop or charge), result registered and result beat handed over. A tick that
// charges the head under a preemptive policy adds a reinsert step after the update.
// The sorted table is a chain of cells; an insert shifts all cells behind the
// insertion point one place right at once, a pop shifts every cell one place left.
// Reset (synchronous, active low) empties the table and clears the totals.
// A stalled result beat holds its output register; no new item is taken
// until the result has been handed over.

module multi_policy_job_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_job_id,
    input  logic [31:0] i_time_now,
    input  logic [15:0] i_run_length,
    input  logic [7:0]  i_job_priority,
    input  logic        i_running_present,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_next_valid,
    output logic [15:0] o_next_job_id,
    output logic        o_dropped,
    output logic [31:0] o_jobs_done,
    output logic [47:0] o_wait_sum,
    output logic [47:0] o_response_sum,
    output logic [47:0] o_turnaround_sum,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int Depth = mpjs_pkg::TableDepth;

    // Sequencer states
    localparam logic [1:0] StIdle   = 2'd0;
    localparam logic [1:0] StUpdate = 2'd1;
    localparam logic [1:0] StRein   = 2'd2;
    localparam logic [1:0] StReport = 2'd3;

    logic [1:0]           r_state;
    logic [2:0]           r_policy;
    logic [1:0]           r_mode;
    logic [31:0]          r_time;
    logic                 r_running;
    logic                 r_drop;
    mpjs_pkg::t_job       r_new;
    logic                 r_out_valid;
    logic                 r_next_valid;
    logic [15:0]          r_next_id;
    logic                 r_dropped;

    mpjs_pkg::t_cell_cmd  w_cmd;
    logic [Depth-1:0]     w_valid;
    logic [Depth-1:0]     w_before;
    mpjs_pkg::t_job       w_job [Depth];
    logic                 w_full;
    logic                 w_finish;
    logic                 w_preempt;
    logic                 w_take;

    // APB register: always ready, policy at address 0
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {29'd0, r_policy} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= mpjs_pkg::PolFcfs;
        end else if (psel && penable && pwrite && paddr == 1'b0) begin
            r_policy <= pwdata[2:0];
        end
    end

    assign w_take    = i_valid && !o_stall;
    assign o_stall   = (r_state != StIdle) || r_out_valid;
    assign w_full    = w_valid[Depth-1];
    assign w_finish  = (r_state == StUpdate) && (r_mode == mpjs_pkg::ModeFinish) && w_valid[0];
    assign w_preempt = (r_policy == mpjs_pkg::PolPpri) || (r_policy == mpjs_pkg::PolPsrtf)
                    || (r_policy == mpjs_pkg::PolRr);

    // Drive one command to the chain per cycle
    always_comb begin
        w_cmd = '0;
        unique case (r_state)
            StUpdate: begin
                w_cmd.insert = (r_mode == mpjs_pkg::ModeNew) && !w_full;
                w_cmd.pop    = w_finish;
                w_cmd.charge = (r_mode == mpjs_pkg::ModeTick) && r_running;
            end
            StRein: begin
                // reinsert the charged head: pop and insert are done by
                // capturing the head first, so here pop, next state inserts
                w_cmd.pop = 1'b1;
            end
            StReport: w_cmd.insert = (r_mode == mpjs_pkg::ModeTick);
            default:  w_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                StIdle:   if (w_take) r_state <= StUpdate;
                StUpdate: begin
                    // reinsert only when a preemptive policy charged a job
                    if (r_mode == mpjs_pkg::ModeTick && r_running && w_valid[0]
                        && w_preempt)
                        r_state <= StRein;
                    else begin
                        r_state <= StReport;
                        r_mode  <= mpjs_pkg::ModeNop;    // nothing more to do in report
                    end
                end
                StRein:   r_state <= StReport;
                StReport: begin
                    r_state     <= StIdle;
                    r_out_valid <= 1'b1;
                end
                default:  r_state <= StIdle;
            endcase
        end
        // Capture the item
        if (w_take) begin
            r_mode    <= i_mode;
            r_time    <= i_time_now;
            r_running <= i_running_present;
            r_drop    <= (i_mode == mpjs_pkg::ModeNew) && w_full;
            r_new     <= '{id: i_job_id, arrival: i_time_now, remaining: i_run_length,
                           required: i_run_length, last_run: 32'd0, has_run: 1'b0,
                           start: 32'd0, started: 1'b0, priority_lvl: i_job_priority};
        end
        // Hold the charged head as the job to reinsert
        if (r_state == StRein) r_new <= w_job[0];
        // Register the result beat
        if (r_state == StReport) begin
            r_next_valid <= (w_cmd.insert) ? 1'b1 : w_valid[0];
            if (w_cmd.insert) begin
                r_next_id <= (!w_valid[0] || w_before[0]) ? r_new.id : w_job[0].id;
            end else if (w_valid[0]) begin
                r_next_id <= w_job[0].id;
            end else begin
                r_next_id <= 16'd0;
            end
            r_dropped <= r_drop;
        end
    end

    // Chain of cells
    genvar g;
    generate
        for (g = 0; g < Depth; g++) begin : g_cell
            mpjs_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_cmd         (w_cmd),
                .i_policy      (r_policy),
                .i_is_head     (g == 0),
                .i_time_now    (r_time),
                .i_new_job     (r_new),
                .i_left_valid  ((g == 0) ? 1'b0 : w_valid[(g == 0) ? 0 : g-1]),
                .i_left_before ((g == 0) ? 1'b0 : w_before[(g == 0) ? 0 : g-1]),
                .i_left_job    (w_job[(g == 0) ? 0 : g-1]),
                .i_right_valid ((g == Depth-1) ? 1'b0 : w_valid[(g == Depth-1) ? g : g+1]),
                .i_right_job   (w_job[(g == Depth-1) ? g : g+1]),
                .o_valid       (w_valid[g]),
                .o_before      (w_before[g]),
                .o_job         (w_job[g])
            );
        end
    endgenerate

    mpjs_totals u_totals (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (w_finish),
        .i_time_now       (r_time),
        .i_job            (w_job[0]),
        .o_jobs_done      (o_jobs_done),
        .o_wait_sum       (o_wait_sum),
        .o_response_sum   (o_response_sum),
        .o_turnaround_sum (o_turnaround_sum)
    );

    assign o_valid       = r_out_valid;
    assign o_next_valid  = r_next_valid;
    assign o_next_job_id = r_next_id;
    assign o_dropped     = r_dropped;

endmodule

>>> hw/rtl/mpjs_cell.sv
// One table cell of the scheduler chain: holds a job and its valid bit.
// Depends on mpjs_pkg.
`timescale 1ns / 1ps

module mpjs_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mpjs_pkg::t_cell_cmd  i_cmd,
    input  logic [2:0]           i_policy,
    input  logic                 i_is_head,
    input  logic [31:0]          i_time_now,
    input  mpjs_pkg::t_job       i_new_job,
    input  logic                 i_left_valid,
    input  logic                 i_left_before,  // new job lands at or left of left cell
    input  mpjs_pkg::t_job       i_left_job,
    input  logic                 i_right_valid,
    input  mpjs_pkg::t_job       i_right_job,
    output logic                 o_valid,
    output logic                 o_before,       // new job lands at or left of this cell
    output mpjs_pkg::t_job       o_job
);

    logic           r_valid;
    mpjs_pkg::t_job r_job;
    logic           n_valid;
    mpjs_pkg::t_job n_job;
    logic           w_before;
    logic           w_here;

    // An empty cell counts as "goes before" so insertion lands at the tail
    assign w_before = !r_valid || mpjs_pkg::goes_before(i_policy, i_new_job, r_job);
    // Insertion point is the first cell the new job goes before; carry it right
    assign w_here   = w_before || i_left_before;

    always_comb begin
        n_valid = r_valid;
        n_job   = r_job;
        priority if (i_cmd.pop) begin
            n_valid = i_right_valid;
            n_job   = i_right_job;
        end else if (i_cmd.insert) begin
            if (w_here) begin
                if (i_is_head || !i_left_before) begin
                    n_valid = 1'b1;
                    n_job   = i_new_job;
                end else begin
                    n_valid = i_left_valid;
                    n_job   = i_left_job;
                end
            end
        end else if (i_cmd.charge && i_is_head && r_valid) begin
            n_job.last_run = i_time_now;
            n_job.has_run  = 1'b1;
            if (r_job.remaining != 16'd0) n_job.remaining = r_job.remaining - 16'd1;
            if (!r_job.started) begin
                n_job.start   = i_time_now;
                n_job.started = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_job <= n_job;
    end

    assign o_valid  = r_valid;
    assign o_before = w_here;
    assign o_job    = r_job;

endmodule

>>> hw/rtl/mpjs_totals.sv
// Saturating statistics accumulators: a finish first registers its wait, response and turnaround terms, then adds them.
// Depends on mpjs_pkg.
`timescale 1ns / 1ps

module mpjs_totals (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,      // head job retires this cycle
    input  logic [31:0]         i_time_now,
    input  mpjs_pkg::t_job      i_job,
    output logic [31:0]         o_jobs_done,
    output logic [47:0]         o_wait_sum,
    output logic [47:0]         o_response_sum,
    output logic [47:0]         o_turnaround_sum
);

    logic        r_stage;
    logic [33:0] r_turn;    // signed terms, 34 bits
    logic [33:0] r_wait;
    logic [33:0] r_resp;
    logic [31:0] r_done;
    logic [47:0] r_wsum;
    logic [47:0] r_rsum;
    logic [47:0] r_tsum;

    logic [33:0] w_t;
    logic [33:0] w_arr;
    logic [33:0] w_st;
    logic [48:0] w_wadd;
    logic [48:0] w_tadd;
    logic [48:0] w_radd;

    assign w_t   = {2'b00, i_time_now};
    assign w_arr = {2'b00, i_job.arrival};
    assign w_st  = (i_job.started ? {2'b00, i_job.start} : w_t) - 34'd1;

    assign w_wadd = {1'b0, r_wsum} + {15'd0, r_wait};
    assign w_tadd = {1'b0, r_tsum} + {15'd0, r_turn};
    assign w_radd = {r_rsum[47], r_rsum} + {{15{r_resp[33]}}, r_resp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_done  <= '0;
            r_wsum  <= '0;
            r_rsum  <= '0;
            r_tsum  <= '0;
        end else begin
            r_stage <= i_start;
            if (i_start && r_done != 32'hFFFF_FFFF) r_done <= r_done + 32'd1;
            if (r_stage) begin
                if (!r_wait[33]) r_wsum <= w_wadd[48] ? mpjs_pkg::MaxU48 : w_wadd[47:0];
                if (!r_turn[33]) r_tsum <= w_tadd[48] ? mpjs_pkg::MaxU48 : w_tadd[47:0];
                if (w_radd[48] != w_radd[47])
                    r_rsum <= w_radd[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                else
                    r_rsum <= w_radd[47:0];
            end
        end
        if (i_start) begin
            r_turn <= w_t - w_arr;
            r_wait <= w_t - w_arr - {18'd0, i_job.required};
            r_resp <= w_st - w_arr;
        end
    end

    assign o_jobs_done      = r_done;
    assign o_wait_sum       = r_wsum;
    assign o_response_sum   = r_rsum;
    assign o_turnaround_sum = r_tsum;

endmodule
